// ===== rtl/core/cpsl_pkg.sv =====
// ----------------------------------------------------------------------------
// cpsl_pkg
// Shared types for the common prefix/suffix length block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsl_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 11;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    logic cmp;
    logic pre_ok;
    logic suf_ok;
    logic end_seq;
    logic end_set;
    logic first;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpsl_if.sv =====
// ----------------------------------------------------------------------------
// cpsl_if
// Valid/ready channels for byte requests and length results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpsl_in_if;
  logic              valid;
  logic              ready;
  cpsl_pkg::byte_t   base;
  cpsl_pkg::len_t    seq_length;
  logic              last_in_seq;
  logic              last_seq;
  cpsl_pkg::len_t    suffix_limit;

  modport source (output valid, base, seq_length, last_in_seq, last_seq, suffix_limit,
                  input ready);
  modport sink   (input valid, base, seq_length, last_in_seq, last_seq, suffix_limit,
                  output ready);
endinterface

interface cpsl_out_if;
  logic              valid;
  logic              ready;
  cpsl_pkg::len_t    prefix_len;
  cpsl_pkg::len_t    suffix_len;
  cpsl_pkg::len_t    min_len;

  modport source (output valid, prefix_len, suffix_len, min_len, input ready);
  modport sink   (input valid, prefix_len, suffix_len, min_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cpsl_ram.sv =====
// ----------------------------------------------------------------------------
// cpsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpsl_addr.sv =====
// ----------------------------------------------------------------------------
// cpsl_addr
// Request stage: byte position, reference store writes, lookup addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsl_addr #(
  parameter int MAX_LEN = 1024,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int PW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  cpsl_in_if.sink                   in_req,
  input  wire logic                 s1_adv,
  output logic                      we,
  output logic [AW-1:0]             waddr,
  output cpsl_pkg::byte_t           wdata,
  output logic                      re,
  output logic [AW-1:0]             raddr_pre,
  output logic [AW-1:0]             raddr_suf,
  output logic                      s1_valid_r,
  output cpsl_pkg::stage_ctl_t      s1_ctl_r,
  output cpsl_pkg::byte_t           s1_base_r,
  output cpsl_pkg::len_t            s1_limit_r,
  output logic [PW-1:0]             s1_len_r
);
  import cpsl_pkg::*;

  localparam int WW = ((PW > LEN_W) ? PW : LEN_W) + 1;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] ref_len_r, ref_len_nxt;
  logic          first_r, first_nxt;
  logic          s1_valid_nxt;
  stage_ctl_t    s1_ctl_nxt;
  byte_t         s1_base_nxt;
  len_t          s1_limit_nxt;
  logic [PW-1:0] s1_len_nxt;

  logic          accept;
  logic          active;
  logic [WW-1:0] p_w, len_w, ref_w, d_w, ri_w, n_w;
  logic          pre_ok, suf_ok;

  assign in_req.ready = !s1_valid_r || s1_adv;
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    p_w    = WW'(pos_r);
    len_w  = WW'(in_req.seq_length);
    ref_w  = WW'(ref_len_r);
    active = p_w < WW'(MAX_LEN);
    d_w    = len_w - p_w - WW'(1);
    ri_w   = ref_w - d_w - WW'(1);
    pre_ok = p_w < ref_w;
    suf_ok = (p_w < len_w) && (d_w < ref_w);
    n_w    = p_w + WW'(active);
  end

  assign we        = accept && active && first_r;
  assign waddr     = pos_r[AW-1:0];
  assign wdata     = in_req.base;
  assign re        = accept && active && !first_r;
  assign raddr_pre = pos_r[AW-1:0];
  assign raddr_suf = ri_w[AW-1:0];

  always_comb begin
    pos_nxt      = pos_r;
    ref_len_nxt  = ref_len_r;
    first_nxt    = first_r;
    s1_valid_nxt = s1_adv ? 1'b0 : s1_valid_r;
    s1_ctl_nxt   = s1_ctl_r;
    s1_base_nxt  = s1_base_r;
    s1_limit_nxt = s1_limit_r;
    s1_len_nxt   = s1_len_r;
    if (accept) begin
      s1_valid_nxt       = 1'b1;
      s1_ctl_nxt.cmp     = active && !first_r;
      s1_ctl_nxt.pre_ok  = pre_ok;
      s1_ctl_nxt.suf_ok  = suf_ok;
      s1_ctl_nxt.end_seq = in_req.last_in_seq;
      s1_ctl_nxt.end_set = in_req.last_seq;
      s1_ctl_nxt.first   = first_r;
      s1_base_nxt        = in_req.base;
      s1_limit_nxt       = in_req.suffix_limit;
      s1_len_nxt         = n_w[PW-1:0];
      if (in_req.last_in_seq) begin
        pos_nxt   = '0;
        first_nxt = in_req.last_seq;
        if (first_r) begin
          ref_len_nxt = n_w[PW-1:0];
        end
      end else begin
        pos_nxt = n_w[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ref_len_r  <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      ref_len_r  <= ref_len_nxt;
      first_r    <= first_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    s1_ctl_r   <= s1_ctl_nxt;
    s1_base_r  <= s1_base_nxt;
    s1_limit_r <= s1_limit_nxt;
    s1_len_r   <= s1_len_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpsl_acc.sv =====
// ----------------------------------------------------------------------------
// cpsl_acc
// Compare stage: match counting, running minima and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsl_acc #(
  parameter int MAX_LEN = 1024,
  localparam int PW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 s1_valid,
  input  wire cpsl_pkg::stage_ctl_t s1_ctl,
  input  wire cpsl_pkg::byte_t      s1_base,
  input  wire cpsl_pkg::len_t       s1_limit,
  input  wire logic [PW-1:0]        s1_len,
  input  wire cpsl_pkg::byte_t      rd_pre,
  input  wire cpsl_pkg::byte_t      rd_suf,
  output logic                      s1_adv,
  cpsl_out_if.source                out_res
);
  import cpsl_pkg::*;

  localparam int WW = ((PW > LEN_W) ? PW : LEN_W) + 1;

  logic [PW-1:0] cur_pre_r, cur_pre_nxt;
  logic [PW-1:0] cur_suf_r, cur_suf_nxt;
  logic          broken_r, broken_nxt;
  logic [PW-1:0] best_pre_r, best_pre_nxt;
  logic [PW-1:0] best_suf_r, best_suf_nxt;
  logic [PW-1:0] short_r, short_nxt;
  logic          out_valid_r, out_valid_nxt;
  len_t          pre_len_r, pre_len_nxt;
  len_t          suf_len_r, suf_len_nxt;
  len_t          min_len_r, min_len_nxt;

  logic          has_res, fire;
  logic          pre_try, pre_match, suf_match;
  logic [PW-1:0] cur_pre_upd, cur_suf_upd;
  logic          broken_upd;
  logic [PW-1:0] bp_upd, bs_upd, sh_upd;
  logic [WW-1:0] bp_w, bs_w, sh_w, lim_w, pre_o, suf_t, suf_o;

  assign has_res = s1_ctl.end_seq && s1_ctl.end_set;
  assign s1_adv  = !has_res || !out_valid_r || out_res.ready;
  assign fire    = s1_valid && s1_adv;

  always_comb begin
    pre_try     = s1_ctl.cmp && !broken_r;
    pre_match   = s1_ctl.pre_ok && (rd_pre == s1_base);
    suf_match   = s1_ctl.suf_ok && (rd_suf == s1_base);
    cur_pre_upd = (pre_try && pre_match) ? cur_pre_r + PW'(1) : cur_pre_r;
    broken_upd  = broken_r || (pre_try && !pre_match);
    cur_suf_upd = cur_suf_r;
    if (s1_ctl.cmp) begin
      cur_suf_upd = suf_match ? cur_suf_r + PW'(1) : '0;
    end

    bp_upd = best_pre_r;
    bs_upd = best_suf_r;
    sh_upd = short_r;
    if (s1_ctl.first) begin
      bp_upd = s1_len;
      bs_upd = s1_len;
      sh_upd = s1_len;
    end else begin
      bp_upd = (cur_pre_upd < best_pre_r) ? cur_pre_upd : best_pre_r;
      bs_upd = (cur_suf_upd < best_suf_r) ? cur_suf_upd : best_suf_r;
      sh_upd = (s1_len < short_r) ? s1_len : short_r;
    end

    bp_w  = WW'(bp_upd);
    bs_w  = WW'(bs_upd);
    sh_w  = WW'(sh_upd);
    lim_w = WW'(s1_limit);
    pre_o = (bp_w < sh_w) ? bp_w : sh_w;
    suf_t = (bs_w < lim_w) ? bs_w : lim_w;
    suf_o = (suf_t < sh_w) ? suf_t : sh_w;
  end

  always_comb begin
    cur_pre_nxt   = cur_pre_r;
    cur_suf_nxt   = cur_suf_r;
    broken_nxt    = broken_r;
    best_pre_nxt  = best_pre_r;
    best_suf_nxt  = best_suf_r;
    short_nxt     = short_r;
    out_valid_nxt = out_res.ready ? 1'b0 : out_valid_r;
    pre_len_nxt   = pre_len_r;
    suf_len_nxt   = suf_len_r;
    min_len_nxt   = min_len_r;
    if (fire) begin
      if (s1_ctl.end_seq) begin
        cur_pre_nxt = '0;
        cur_suf_nxt = '0;
        broken_nxt  = 1'b0;
        if (s1_ctl.end_set) begin
          best_pre_nxt  = '0;
          best_suf_nxt  = '0;
          short_nxt     = '0;
          out_valid_nxt = 1'b1;
          pre_len_nxt   = pre_o[LEN_W-1:0];
          suf_len_nxt   = suf_o[LEN_W-1:0];
          min_len_nxt   = sh_w[LEN_W-1:0];
        end else begin
          best_pre_nxt = bp_upd;
          best_suf_nxt = bs_upd;
          short_nxt    = sh_upd;
        end
      end else begin
        cur_pre_nxt = cur_pre_upd;
        cur_suf_nxt = cur_suf_upd;
        broken_nxt  = broken_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pre_r   <= '0;
      cur_suf_r   <= '0;
      broken_r    <= 1'b0;
      best_pre_r  <= '0;
      best_suf_r  <= '0;
      short_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_pre_r   <= cur_pre_nxt;
      cur_suf_r   <= cur_suf_nxt;
      broken_r    <= broken_nxt;
      best_pre_r  <= best_pre_nxt;
      best_suf_r  <= best_suf_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pre_len_r <= pre_len_nxt;
    suf_len_r <= suf_len_nxt;
    min_len_r <= min_len_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.prefix_len = pre_len_r;
  assign out_res.suffix_len = suf_len_r;
  assign out_res.min_len    = min_len_r;

endmodule

`default_nettype wire

// ===== rtl/core/common_prefix_suffix_length_top.sv =====
// ----------------------------------------------------------------------------
// common_prefix_suffix_length_top
// Common prefix and suffix length over a set of streamed byte sequences.
//
//   channel   dir   handshake           payload
//   in_req    in    valid/ready         base, seq_length, last_in_seq,
//                                       last_seq, suffix_limit
//   out_res   out   valid/ready         prefix_len, suffix_len, min_len
//
// One byte request per cycle while the compare stage advances; the set's final
// byte is registered into the request stage, and out_res.valid is registered
// as the compare stage takes it. The reference bytes sit in two copies of a
// MAX_LEN x 8 RAM, one read for the prefix offset and one for the suffix
// offset, each with registered read data. No clearing pass after reset.
// A held result stalls the compare stage only when another result is due.
`default_nettype none

module common_prefix_suffix_length_top #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cpsl_in_if.sink     in_req,
  cpsl_out_if.source  out_res
);
  import cpsl_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PW = $clog2(MAX_LEN + 1);

  logic          we, re, s1_adv, s1_valid;
  logic [AW-1:0] waddr, raddr_pre, raddr_suf;
  byte_t         wdata, rd_pre, rd_suf, s1_base;
  stage_ctl_t    s1_ctl;
  len_t          s1_limit;
  logic [PW-1:0] s1_len;

  cpsl_addr #(.MAX_LEN(MAX_LEN)) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .s1_adv     (s1_adv),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr_pre  (raddr_pre),
    .raddr_suf  (raddr_suf),
    .s1_valid_r (s1_valid),
    .s1_ctl_r   (s1_ctl),
    .s1_base_r  (s1_base),
    .s1_limit_r (s1_limit),
    .s1_len_r   (s1_len)
  );

  cpsl_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_ram_pre (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_pre),
    .rdata (rd_pre)
  );

  cpsl_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_ram_suf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_suf),
    .rdata (rd_suf)
  );

  cpsl_acc #(.MAX_LEN(MAX_LEN)) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_base  (s1_base),
    .s1_limit (s1_limit),
    .s1_len   (s1_len),
    .rd_pre   (rd_pre),
    .rd_suf   (rd_suf),
    .s1_adv   (s1_adv),
    .out_res  (out_res)
  );

endmodule

`default_nettype wire
